// ----- rtl/fpa_pkg.sv -----
`timescale 1ns / 1ps

package fpa_pkg;

   // page count the block is built for unless told otherwise
   localparam int DEFAULT_PAGE_COUNT = 256;

   // walk counter width: covers a start page plus two full sweeps
   localparam int CNT_W = 10;

   // field widths
   localparam int MODE_W  = 2;
   localparam int PAGE_W  = 8;
   localparam int COUNT_W = 8;

   // request modes
   localparam logic [MODE_W-1:0] MODE_INIT    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

   // per-page state held in the page memory
   typedef enum logic [1:0] {
      PG_NONE  = 2'd0,
      PG_FREE  = 2'd1,
      PG_ALLOC = 2'd2
   } page_state_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_INIT,
      S_SCAN,
      S_MARK,
      S_RELEASE,
      S_DONE
   } seq_state_type;

endpackage

// ----- rtl/first_fit_page_run_allocator.sv -----
`timescale 1ns / 1ps

// First-fit page run allocator. Every page is free, allocated or neither (the
// state after reset). A beat with mode init marks count pages from first_page
// onward free, clipped at the last page. Mode allocate finds the lowest-addressed
// run of count adjacent free pages, marks it allocated and returns its start; a
// count of zero or no fitting run fails with success 0. Mode release walks forward
// from first_page freeing allocated pages until count are done, the last page
// is reached or a page that is not allocated is met, and returns how many were
// freed. One request is in work at a time, and req_stall stays high until its
// response is placed in the output register; a new request is taken while that
// response still waits. Page state sits in one memory with one read and one
// write port, and the sequencer touches one page per cycle: init writes its
// clipped range, allocate scans for a run and then marks it, release reads and
// frees pages in turn, and zero-count or unused-mode requests walk nothing.
// A per-page valid flop, cleared by reset, makes a never-written page read as
// neither free nor allocated, so no clearing pass is needed.
module first_fit_page_run_allocator #(
   parameter int PAGE_COUNT = fpa_pkg::DEFAULT_PAGE_COUNT
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [fpa_pkg::MODE_W-1:0]   req_mode,
   input  logic [fpa_pkg::PAGE_W-1:0]   req_first_page,
   input  logic [fpa_pkg::COUNT_W-1:0]  req_count,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [fpa_pkg::PAGE_W-1:0]   rsp_run_start,
   output logic                         rsp_success,
   output logic [fpa_pkg::COUNT_W-1:0]  rsp_released
);

   localparam int PW = $clog2(PAGE_COUNT);
   localparam int CW = fpa_pkg::CNT_W;
   localparam logic [CW-1:0] PAGE_N    = CW'(PAGE_COUNT);
   localparam logic [CW-1:0] PAGE_LAST = CW'(PAGE_COUNT - 1);

   // page memory and its valid flops
   fpa_pkg::page_state_type page_mem [PAGE_COUNT];
   logic [PAGE_COUNT-1:0]   valid_ff;

   // sequencer
   fpa_pkg::seq_state_type state_ff, state_in;

   // walk registers
   logic [CW-1:0]                ptr_ff, ptr_in;       // read issue / write pointer
   logic [CW-1:0]                end_ff, end_in;       // init end (exclusive) or mark end
   logic [CW-1:0]                eval_ff, eval_in;     // page whose read data is back
   logic                         pend_ff, pend_in;     // read data is meaningful
   logic [fpa_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [fpa_pkg::COUNT_W-1:0]  run_len_ff, run_len_in;
   logic [CW-1:0]                run_begin_ff, run_begin_in;
   logic [fpa_pkg::COUNT_W-1:0]  done_ff, done_in;

   // read port
   logic [PW-1:0]           rd_idx;
   fpa_pkg::page_state_type rd_mem_ff;
   logic                    rd_vld_ff;
   fpa_pkg::page_state_type cur_page;

   // write port
   logic                    wr_en;
   logic [PW-1:0]           wr_idx;
   fpa_pkg::page_state_type wr_data;

   // result held until the output register is free
   logic [fpa_pkg::PAGE_W-1:0]   res_start_ff, res_start_in;
   logic                         res_success_ff, res_success_in;
   logic [fpa_pkg::COUNT_W-1:0]  res_released_ff, res_released_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [fpa_pkg::PAGE_W-1:0]   rsp_start_ff, rsp_start_in;
   logic                         rsp_success_ff, rsp_success_in;
   logic [fpa_pkg::COUNT_W-1:0]  rsp_released_ff, rsp_released_in;

   // decoded conditions shared by the next-state and output blocks
   logic                         req_take;
   logic                         out_free;
   logic                         ptr_in_range;
   logic                         eval_in_range;
   logic                         init_go;
   logic                         scan_hit;
   logic                         scan_found;
   logic                         scan_end;
   logic [fpa_pkg::COUNT_W-1:0]  run_len_next;
   logic [CW-1:0]                run_begin_next;
   logic                         rel_ok;
   logic                         rel_finish;
   logic [fpa_pkg::COUNT_W-1:0]  done_next;

   assign req_stall = (state_ff != fpa_pkg::S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_run_start = rsp_start_ff;
   assign rsp_success   = rsp_success_ff;
   assign rsp_released  = rsp_released_ff;

   // page that the read data belongs to, never-written pages read as neither
   assign cur_page = rd_vld_ff ? rd_mem_ff : fpa_pkg::PG_NONE;

   assign ptr_in_range  = (ptr_ff < PAGE_N);
   assign eval_in_range = (eval_ff < PAGE_N);

   // init: one page per cycle while inside the clipped range
   assign init_go = (ptr_ff < end_ff) && ptr_in_range;

   // allocate scan: extend or break the current free run
   assign scan_hit       = pend_ff && (cur_page == fpa_pkg::PG_FREE);
   assign run_len_next   = scan_hit ? run_len_ff + 1'b1 : '0;
   assign run_begin_next = (scan_hit && run_len_ff == '0) ? eval_ff : run_begin_ff;
   assign scan_found     = scan_hit && (run_len_next == count_ff);
   assign scan_end       = pend_ff && (eval_ff == PAGE_LAST);

   // release walk: free while allocated, stop on count or end of map
   assign rel_ok     = pend_ff && eval_in_range && (cur_page == fpa_pkg::PG_ALLOC);
   assign done_next  = rel_ok ? done_ff + 1'b1 : done_ff;
   assign rel_finish = pend_ff &&
                       (!rel_ok || done_next == count_ff || eval_ff == PAGE_LAST);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fpa_pkg::S_IDLE: begin
            if (req_take) begin
               if (req_mode == fpa_pkg::MODE_INIT) begin
                  state_in = fpa_pkg::S_INIT;
               end else if (req_mode == fpa_pkg::MODE_ALLOC && req_count != '0) begin
                  state_in = fpa_pkg::S_SCAN;
               end else if (req_mode == fpa_pkg::MODE_RELEASE && req_count != '0) begin
                  state_in = fpa_pkg::S_RELEASE;
               end else begin
                  // unused mode or zero count: nothing to walk
                  state_in = fpa_pkg::S_DONE;
               end
            end
         end
         fpa_pkg::S_INIT: begin
            if (!init_go) begin
               state_in = fpa_pkg::S_DONE;
            end
         end
         fpa_pkg::S_SCAN: begin
            if (scan_found) begin
               state_in = fpa_pkg::S_MARK;
            end else if (scan_end) begin
               state_in = fpa_pkg::S_DONE;
            end
         end
         fpa_pkg::S_MARK: begin
            if (ptr_ff == end_ff) begin
               state_in = fpa_pkg::S_DONE;
            end
         end
         fpa_pkg::S_RELEASE: begin
            if (rel_finish) begin
               state_in = fpa_pkg::S_DONE;
            end
         end
         fpa_pkg::S_DONE: begin
            if (out_free) begin
               state_in = fpa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = fpa_pkg::S_IDLE;
         end
      endcase
   end

   // datapath and memory controls
   always_comb begin
      ptr_in          = ptr_ff;
      end_in          = end_ff;
      eval_in         = eval_ff;
      pend_in         = pend_ff;
      count_in        = count_ff;
      run_len_in      = run_len_ff;
      run_begin_in    = run_begin_ff;
      done_in         = done_ff;
      res_start_in    = res_start_ff;
      res_success_in  = res_success_ff;
      res_released_in = res_released_ff;
      rd_idx          = ptr_in_range ? ptr_ff[PW-1:0] : '0;
      wr_en           = 1'b0;
      wr_idx          = ptr_ff[PW-1:0];
      wr_data         = fpa_pkg::PG_FREE;

      // output register drains on its own; a new response loads it in S_DONE
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_start_in    = rsp_start_ff;
      rsp_success_in  = rsp_success_ff;
      rsp_released_in = rsp_released_ff;

      case (state_ff)
         fpa_pkg::S_IDLE: begin
            if (req_take) begin
               ptr_in          = CW'(req_first_page);
               end_in          = CW'(req_first_page) + CW'(req_count);
               eval_in         = '0;
               pend_in         = 1'b0;
               count_in        = req_count;
               run_len_in      = '0;
               run_begin_in    = '0;
               done_in         = '0;
               res_start_in    = '0;
               res_success_in  = (req_mode == fpa_pkg::MODE_INIT);
               res_released_in = '0;
               if (req_mode == fpa_pkg::MODE_ALLOC) begin
                  ptr_in = '0;
               end
            end
         end
         fpa_pkg::S_INIT: begin
            if (init_go) begin
               wr_en   = 1'b1;
               wr_idx  = ptr_ff[PW-1:0];
               wr_data = fpa_pkg::PG_FREE;
               ptr_in  = ptr_ff + 1'b1;
            end
         end
         fpa_pkg::S_SCAN: begin
            // issue the next read while the previous page is judged
            ptr_in       = ptr_ff + 1'b1;
            eval_in      = ptr_ff;
            pend_in      = 1'b1;
            run_len_in   = run_len_next;
            run_begin_in = run_begin_next;
            if (scan_found) begin
               ptr_in       = run_begin_next;
               end_in       = eval_ff;
               res_start_in = run_begin_next[fpa_pkg::PAGE_W-1:0];
            end
         end
         fpa_pkg::S_MARK: begin
            wr_en   = 1'b1;
            wr_idx  = ptr_ff[PW-1:0];
            wr_data = fpa_pkg::PG_ALLOC;
            ptr_in  = ptr_ff + 1'b1;
            if (ptr_ff == end_ff) begin
               res_success_in = 1'b1;
            end
         end
         fpa_pkg::S_RELEASE: begin
            ptr_in  = ptr_ff + 1'b1;
            eval_in = ptr_ff;
            pend_in = 1'b1;
            done_in = done_next;
            if (rel_ok) begin
               wr_en   = 1'b1;
               wr_idx  = eval_ff[PW-1:0];
               wr_data = fpa_pkg::PG_FREE;
            end
            if (rel_finish) begin
               res_released_in = done_next;
               res_success_in  = (done_next != '0);
            end
         end
         fpa_pkg::S_DONE: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_start_in    = res_start_ff;
               rsp_success_in  = res_success_ff;
               rsp_released_in = res_released_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fpa_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ptr_ff          <= ptr_in;
      end_ff          <= end_in;
      eval_ff         <= eval_in;
      count_ff        <= count_in;
      run_len_ff      <= run_len_in;
      run_begin_ff    <= run_begin_in;
      done_ff         <= done_in;
      res_start_ff    <= res_start_in;
      res_success_ff  <= res_success_in;
      res_released_ff <= res_released_in;
      rsp_start_ff    <= rsp_start_in;
      rsp_success_ff  <= rsp_success_in;
      rsp_released_ff <= rsp_released_in;
   end

   // page memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         page_mem[wr_idx] <= wr_data;
      end
      rd_mem_ff <= page_mem[rd_idx];
   end

   // valid flops: a page counts only once it has been written
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_vld_ff <= valid_ff[rd_idx];
   end

endmodule

// ----- sim/tb_first_fit_page_run_allocator.sv -----
`timescale 1ns / 1ps

module tb_first_fit_page_run_allocator;
   import fpa_pkg::*;

   localparam int PAGES = DEFAULT_PAGE_COUNT;

   // the one mode the block has no use for: no state change, all-zero response
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   // limit on the whole run, well beyond the slowest legal run
   localparam longint RUN_LIMIT_NS = 64'd60_000_000;

   typedef struct packed {
      logic [PAGE_W-1:0]  run_start;
      logic               success;
      logic [COUNT_W-1:0] released;
   } page_rsp_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [MODE_W-1:0]  req_mode = MODE_INIT;
   logic [PAGE_W-1:0]  req_first_page = '0;
   logic [COUNT_W-1:0] req_count = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [PAGE_W-1:0]  rsp_run_start;
   logic               rsp_success;
   logic [COUNT_W-1:0] rsp_released;

   // shadow of the page map, one bit per page for each of the two states
   bit pages_free  [PAGES];
   bit pages_taken [PAGES];

   // responses owed by the block, oldest first
   page_rsp_t pending_rsp[$];
   // starts of runs handed out, used to aim releases at live allocations
   int live_runs[$];

   int error_count = 0;
   // when set, neither side inserts idle cycles
   bit no_idle = 1'b0;
   // long receiver hold-off: the test bumps hold_seq, the receiver picks it up
   int hold_seq = 0;
   int hold_len = 0;

   first_fit_page_run_allocator #(
      .PAGE_COUNT(PAGES)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_first_page (req_first_page),
      .req_count      (req_count),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_run_start  (rsp_run_start),
      .rsp_success    (rsp_success),
      .rsp_released   (rsp_released)
   );

   always #10 clock = ~clock;

   initial begin
      #(RUN_LIMIT_NS);
      $display("first_fit_page_run_allocator verification failed");
      $finish;
   end

   task automatic report_error(input string msg);
      $display("ERROR at %0t ns: %s", $realtime, msg);
      error_count++;
   endtask

   // idle length: mostly none or a short gap, now and then a long one
   function automatic int idle_len();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // page map predictor: applies one request to the shadow map and returns
   // the response the block owes for it
   function automatic page_rsp_t apply_page_op(input logic [MODE_W-1:0] mode,
                                               input logic [PAGE_W-1:0] first,
                                               input logic [COUNT_W-1:0] count);
      page_rsp_t r;
      int p;
      int run_begin;
      int run_len;
      int done;
      bit found;
      r = '0;
      run_begin = 0;
      run_len = 0;
      done = 0;
      found = 1'b0;
      case (mode)
         MODE_INIT: begin
            // clipped at the last page, start past the end marks nothing
            for (p = int'(first); p < int'(first) + int'(count) && p < PAGES; p++) begin
               pages_free[p]  = 1'b1;
               pages_taken[p] = 1'b0;
            end
            r.success = 1'b1;
         end
         MODE_ALLOC: begin
            // first fit: adjacent free pages form one run however they got free
            if (count != 0) begin
               for (p = 0; p < PAGES && !found; p++) begin
                  if (pages_free[p]) begin
                     if (run_len == 0) run_begin = p;
                     run_len++;
                     if (run_len == int'(count)) found = 1'b1;
                  end else begin
                     run_len = 0;
                  end
               end
               if (found) begin
                  for (p = run_begin; p < run_begin + int'(count); p++) begin
                     pages_free[p]  = 1'b0;
                     pages_taken[p] = 1'b1;
                  end
                  r.run_start = PAGE_W'(run_begin);
                  r.success   = 1'b1;
               end
            end
         end
         MODE_RELEASE: begin
            // walk stops at the count, at the last page, or at a page not allocated
            p = int'(first);
            while (done < int'(count) && p < PAGES && pages_taken[p]) begin
               pages_taken[p] = 1'b0;
               pages_free[p]  = 1'b1;
               done++;
               p++;
            end
            r.released = COUNT_W'(done);
            r.success  = (done > 0);
         end
         default: ;
      endcase
      return r;
   endfunction

   // offer one beat, hold it until taken, predict, then maybe idle a while
   task automatic send_req(input logic [MODE_W-1:0] mode,
                           input logic [PAGE_W-1:0] first,
                           input logic [COUNT_W-1:0] count);
      page_rsp_t owed;
      int gap;
      req_mode       <= mode;
      req_first_page <= first;
      req_count      <= count;
      // valid left high from the previous beat is not touched again
      if (!req_valid) req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      owed = apply_page_op(mode, first, count);
      pending_rsp.push_back(owed);
      if (mode == MODE_ALLOC && owed.success) live_runs.push_back(int'(owed.run_start));
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender pause: drop valid and wait for every owed response
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic check_rsp();
      page_rsp_t want;
      if (pending_rsp.size() == 0) begin
         report_error("response beat with nothing owed");
      end else begin
         want = pending_rsp.pop_front();
         if (rsp_run_start !== want.run_start)
            report_error($sformatf("run_start got %0d want %0d", rsp_run_start, want.run_start));
         if (rsp_success !== want.success)
            report_error($sformatf("success got %0b want %0b", rsp_success, want.success));
         if (rsp_released !== want.released)
            report_error($sformatf("released got %0d want %0d", rsp_released, want.released));
      end
   endtask

   // receiver: checks every taken response beat, then picks the next stall
   always @(posedge clock) begin : rsp_side
      static int hold_seen = 0;
      static int stall_left = 0;
      if (!reset && rsp_valid && !rsp_stall) check_rsp();
      if (hold_seq != hold_seen) begin
         // long hold-off asked by a test, counted down here cycle by cycle
         hold_seen  = hold_seq;
         stall_left = hold_len;
      end else if (stall_left == 0 && !no_idle && $urandom_range(0, 3) == 0) begin
         stall_left = idle_len();
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // nothing is free or allocated right after reset
   task automatic test_empty_map();
      send_req(MODE_ALLOC, 8'd0, 8'd1);
      send_req(MODE_RELEASE, 8'd0, 8'd5);
      send_req(MODE_UNUSED, 8'd255, 8'd255);
      send_req(MODE_INIT, 8'd0, 8'd0);
   endtask

   // init clipped at the last page, release walk stopped by the end of the map
   task automatic test_init_clip();
      send_req(MODE_INIT, 8'd250, 8'd255);
      send_req(MODE_ALLOC, 8'd17, 8'd6);
      send_req(MODE_RELEASE, 8'd250, 8'd255);
      send_req(MODE_INIT, 8'd0, 8'd255);
   endtask

   // zero count, largest count, map full
   task automatic test_alloc_extremes();
      send_req(MODE_ALLOC, 8'd0, 8'd0);
      send_req(MODE_ALLOC, 8'd0, 8'd255);
      send_req(MODE_ALLOC, 8'd0, 8'd2);
      send_req(MODE_ALLOC, 8'd200, 8'd1);
      send_req(MODE_ALLOC, 8'd0, 8'd1);
   endtask

   // zero count, full-length walk, start on a page that is not allocated
   task automatic test_release_extremes();
      send_req(MODE_RELEASE, 8'd10, 8'd0);
      send_req(MODE_RELEASE, 8'd0, 8'd255);
      send_req(MODE_RELEASE, 8'd255, 8'd1);
      send_req(MODE_RELEASE, 8'd255, 8'd1);
   endtask

   // freed neighbors merge into one run; init over allocated pages frees them
   task automatic test_coalesce_and_overlap();
      send_req(MODE_ALLOC, 8'd0, 8'd8);
      send_req(MODE_ALLOC, 8'd0, 8'd8);
      send_req(MODE_RELEASE, 8'd4, 8'd2);
      send_req(MODE_RELEASE, 8'd2, 8'd2);
      send_req(MODE_ALLOC, 8'd0, 8'd4);
      send_req(MODE_ALLOC, 8'd0, 8'd4);
      send_req(MODE_INIT, 8'd17, 8'd2);
      send_req(MODE_RELEASE, 8'd16, 8'd4);
   endtask

   // mostly well-formed traffic: allocations and releases aimed at live runs,
   // with occasional refills, stray releases and unused-mode beats
   task automatic test_random_ops(input int n_items);
      int r;
      int k;
      logic [COUNT_W-1:0] cnt;
      for (int i = 0; i < n_items; i++) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            cnt = ($urandom_range(0, 1) != 0) ? COUNT_W'($urandom_range(1, 32))
                                              : COUNT_W'($urandom_range(0, 255));
            send_req(MODE_INIT, PAGE_W'($urandom_range(0, 255)), cnt);
         end else if (r < 50) begin
            k = $urandom_range(0, 99);
            if (k < 80) cnt = COUNT_W'($urandom_range(1, 12));
            else if (k < 95) cnt = COUNT_W'($urandom_range(13, 64));
            else cnt = COUNT_W'($urandom_range(0, 255));
            send_req(MODE_ALLOC, PAGE_W'($urandom_range(0, 255)), cnt);
         end else if (r < 85 && live_runs.size() != 0) begin
            k = $urandom_range(0, live_runs.size() - 1);
            cnt = ($urandom_range(0, 9) < 7) ? COUNT_W'($urandom_range(1, 16))
                                             : COUNT_W'($urandom_range(0, 255));
            send_req(MODE_RELEASE, PAGE_W'(live_runs[k]), cnt);
            live_runs.delete(k);
         end else if (r < 96) begin
            send_req(MODE_RELEASE, PAGE_W'($urandom_range(0, 255)),
                     COUNT_W'($urandom_range(0, 255)));
         end else begin
            send_req(MODE_UNUSED, PAGE_W'($urandom_range(0, 255)),
                     COUNT_W'($urandom_range(0, 255)));
         end
      end
   endtask

   // back-to-back beats with no idling on either side
   task automatic test_streaming();
      no_idle = 1'b1;
      test_random_ops(60);
      no_idle = 1'b0;
   endtask

   // receiver holds off while beats keep coming, so the
   // response register fills and the request side stalls
   task automatic test_backpressure();
      no_idle  = 1'b1;
      hold_len = 400;
      hold_seq++;
      send_req(MODE_INIT, 8'd64, 8'd32);
      for (int i = 0; i < 10; i++) begin
         send_req(MODE_ALLOC, 8'd0, COUNT_W'($urandom_range(1, 4)));
      end
      send_req(MODE_RELEASE, 8'd64, 8'd255);
      no_idle = 1'b0;
      drain_responses();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_map();
      test_init_clip();
      test_alloc_extremes();
      test_release_extremes();
      test_coalesce_and_overlap();
      drain_responses();

      test_streaming();
      test_backpressure();
      test_random_ops(200);
      drain_responses();
      test_random_ops(200);
      test_streaming();
      test_random_ops(160);

      // tail: wait for every owed response, then give the block time to
      // show any stray beat
      drain_responses();
      repeat (600) @(posedge clock);
      if (pending_rsp.size() != 0) report_error("responses still owed at end of run");
      if (error_count == 0) begin
         $display("first_fit_page_run_allocator verification clean");
      end else begin
         $display("first_fit_page_run_allocator verification failed");
      end
      $finish;
   end

endmodule

// ----- first_fit_page_run_allocator.f -----
rtl/fpa_pkg.sv
rtl/first_fit_page_run_allocator.sv
sim/tb_first_fit_page_run_allocator.sv
